// ===== src/maot_pkg.sv =====
// ----------------------------------------------------------------------------
// maot_pkg - shared constants for the multi-turn angle offset tracker
// Register reset values, angle thresholds and register address indices.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package maot_pkg;

    localparam int unsigned POS_W    = 16;
    localparam int unsigned WIN_W    = 15;
    localparam int unsigned ANGLE_W  = 8;
    localparam int unsigned TURN_W   = 8;
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned PDATA_W  = 32;

    // Register reset values
    localparam logic [POS_W-1:0] CENTER_RESET = 16'h8000;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 15'h5000;

    // Angle thresholds for turn detection
    localparam logic [ANGLE_W-1:0] ANGLE_HIGH_THR = 8'd192;
    localparam logic [ANGLE_W-1:0] ANGLE_LOW_THR  = 8'd63;

    // Register index, taken from paddr[2]
    typedef enum logic {
        t_REG_CENTER = 1'b0,
        t_REG_WINDOW = 1'b1
    } t_reg_idx;

endpackage

`default_nettype wire

// ===== src/multiturn_angle_offset_tracker_top.sv =====
// ----------------------------------------------------------------------------
// multiturn_angle_offset_tracker_top - multi-turn angle tracker with offset
// Counts sensor turns, builds a raw position and keeps a self-adjusting
// offset so that the reported position stays inside a configurable window.
// ----------------------------------------------------------------------------
// Datapath: an input transfer loads the input register, and the item moves on
//   into the result register when that register is free or drains.
// Throughput: one item per cycle; the turn count and offset update is a
//   combinational add/compare/subtract path, so back-to-back items only wait
//   while the result side stalls with both registers full.
// Reset (synchronous, active low): turn count, previous angle and offset
//   clear to zero, registers return to centre 0x8000 and half window 0x5000.
`timescale 1ns / 1ps
`default_nettype none

module multiturn_angle_offset_tracker_top
    import maot_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [7:0]           i_high_byte,
    input  wire logic [7:0]           i_low_byte,
    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [POS_W-1:0]          o_position,
    output logic [POS_W-1:0]          o_offset_value,
    // configuration port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready
);

    // Configuration registers
    logic [POS_W-1:0]   r_center;
    logic [WIN_W-1:0]   r_window;
    logic               cfg_wr;
    t_reg_idx           cfg_idx;

    // Input register
    logic               r_in_valid;
    logic [7:0]         r_high_byte;
    logic [7:0]         r_low_byte;

    // Tracker state
    logic [ANGLE_W-1:0] r_prev_angle;
    logic [TURN_W-1:0]  r_turn;
    logic [POS_W-1:0]   r_offset;

    // Result register
    logic               r_out_valid;
    logic [POS_W-1:0]   r_position;
    logic [POS_W-1:0]   r_offset_out;

    // Update datapath
    logic               advance;
    logic [ANGLE_W-1:0] angle;
    logic               turn_up;
    logic               turn_down;
    logic [TURN_W-1:0]  n_turn;
    logic [POS_W-1:0]   raw;
    logic [POS_W-1:0]   off_init;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   win_ext;
    logic [POS_W-1:0]   left;
    logic [POS_W-1:0]   right;
    logic [POS_W-1:0]   off_lo;
    logic [POS_W-1:0]   n_offset;

    // Configuration write and read
    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        case (cfg_idx)
            t_REG_CENTER: prdata = {{(PDATA_W-POS_W){1'b0}}, r_center};
            t_REG_WINDOW: prdata = {{(PDATA_W-WIN_W){1'b0}}, r_window};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= CENTER_RESET;
            r_window <= WINDOW_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                t_REG_CENTER: r_center <= pwdata[POS_W-1:0];
                t_REG_WINDOW: r_window <= pwdata[WIN_W-1:0];
                default:      ;
            endcase
        end
    end

    // Handshake: the stage advances when the result register is free or drains
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    // Hold or load the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_high_byte <= i_high_byte;
            r_low_byte  <= i_low_byte;
        end
    end

    // Angle, turn detection and raw position
    assign angle     = {r_high_byte[3:0], r_low_byte[7:4]};
    assign turn_up   = (r_prev_angle > ANGLE_HIGH_THR) && (angle < ANGLE_LOW_THR);
    assign turn_down = (angle > ANGLE_HIGH_THR) && (r_prev_angle < ANGLE_LOW_THR);

    always_comb begin
        n_turn = r_turn;
        if (turn_up) begin
            n_turn = r_turn + TURN_W'(1);
        end else if (turn_down) begin
            n_turn = r_turn - TURN_W'(1);
        end
    end

    // Overlapping OR of the three terms is intended
    assign raw = {n_turn[6:0], 9'b0}
               | {7'b0, angle, 1'b0}
               | {11'b0, r_low_byte[7:3]};

    // Initialise the offset while it is still zero
    always_comb begin
        if (r_offset != '0) begin
            off_init = r_offset;
        end else if (raw > r_center) begin
            off_init = raw - r_center;
        end else begin
            off_init = r_center - raw;
        end
    end

    // Window limits, wrapping modulo 2^16
    assign pos     = raw - off_init;
    assign win_ext = {1'b0, r_window};
    assign left    = r_center - win_ext;
    assign right   = r_center + win_ext;

    // Pull the offset so the position falls back inside the window
    assign off_lo   = (pos < left)  ? (off_init - (left - pos)) : off_init;
    assign n_offset = (pos > right) ? (off_lo + (pos - right))  : off_lo;

    // Advance tracker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_angle <= '0;
            r_turn       <= '0;
            r_offset     <= '0;
        end else if (advance) begin
            r_prev_angle <= angle;
            r_turn       <= n_turn;
            r_offset     <= n_offset;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_position   <= pos;
            r_offset_out <= n_offset;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_position     = r_position;
    assign o_offset_value = r_offset_out;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // The offset carried forward is the one that was reported
    a_offset_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_offset == o_offset_value))
        else $error("stored offset differs from reported offset");

    // Upstream is stalled only while an item is held
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with empty input register");

    // A transfer through the stage always yields a result
    a_advance_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("result missing after stage advance");

    // The turn count moves by at most one per item
    a_turn_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((r_turn == $past(r_turn))
            || (r_turn == $past(r_turn) + TURN_W'(1))
            || (r_turn == $past(r_turn) - TURN_W'(1))))
        else $error("turn count jumped");

    // Reset clears the tracker state
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> ((r_offset == '0) && (r_turn == '0) && !o_out_valid))
        else $error("tracker state not cleared by reset");

endmodule

`default_nettype wire

// ===== tb/maot_tracker_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maot_tracker_checker - result predictor and scoreboard for the tracker
// Watches the sample, result and register channels, keeps its own copy of
// the turn count, previous angle and offset, predicts each result and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------

module maot_tracker_checker
    import maot_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // sample channel
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [7:0]         i_high_byte,
    input  logic [7:0]         i_low_byte,
    // result channel
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [POS_W-1:0]   i_position,
    input  logic [POS_W-1:0]   i_offset_value,
    // register port
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    // status towards the testbench top
    output int                 o_mismatches,
    output int                 o_pending,
    output int                 o_results
);

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] offset_value;
    } t_tracker_result;

    t_tracker_result        expected_results[$];

    logic [POS_W-1:0]       trk_center;
    logic [WIN_W-1:0]       trk_window;
    logic [ANGLE_W-1:0]     trk_prev_angle;
    logic [TURN_W-1:0]      trk_turns;
    logic [POS_W-1:0]       trk_offset;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        o_results    = 0;
    end

    // Count a mismatch; report only the first few in full
    task automatic flag_mismatch(input string what, input logic [POS_W-1:0] want,
                                 input logic [POS_W-1:0] got);
        o_mismatches++;
        if (o_mismatches <= 10)
            $display("mismatch at result %0d: %s expected 0x%04h got 0x%04h",
                     o_results, what, want, got);
    endtask

    // Advance the turn count and offset for one sample, queue the result
    task automatic advance_tracker(input logic [7:0] hb, input logic [7:0] lb);
        logic [ANGLE_W-1:0] angle;
        logic [POS_W-1:0]   raw;
        logic [POS_W-1:0]   pos;
        logic [POS_W-1:0]   left;
        logic [POS_W-1:0]   right;
        logic [POS_W-1:0]   off;
        t_tracker_result    res;
        angle = {hb[3:0], lb[7:4]};

        // wrap forwards past zero, or backwards past zero
        if (trk_prev_angle > ANGLE_HIGH_THR && angle < ANGLE_LOW_THR)
            trk_turns = trk_turns + 1'b1;
        if (angle > ANGLE_HIGH_THR && trk_prev_angle < ANGLE_LOW_THR)
            trk_turns = trk_turns - 1'b1;
        trk_prev_angle = angle;

        // overlapping OR of turn, angle and low byte terms
        raw = {trk_turns[6:0], 9'b0} | {7'b0, angle, 1'b0} | {11'b0, lb[7:3]};

        // load the offset while it is still zero
        off = trk_offset;
        if (off == '0) begin
            if (raw > trk_center)
                off = raw - trk_center;
            else
                off = trk_center - raw;
        end

        pos   = raw - off;
        left  = trk_center - {1'b0, trk_window};
        right = trk_center + {1'b0, trk_window};

        // pull the position back into the window; both may apply
        if (pos < left)
            off = off - (left - pos);
        if (pos > right)
            off = off + (pos - right);
        trk_offset = off;

        res.position     = pos;
        res.offset_value = off;
        expected_results.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_tracker_result want;
        if (!i_rst_n) begin
            trk_center     = CENTER_RESET;
            trk_window     = WINDOW_RESET;
            trk_prev_angle = '0;
            trk_turns      = '0;
            trk_offset     = '0;
            expected_results.delete();
        end else begin
            // track register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[2]))
                    t_REG_CENTER: trk_center = i_pwdata[POS_W-1:0];
                    t_REG_WINDOW: trk_window = i_pwdata[WIN_W-1:0];
                    default: ;
                endcase
            end

            // compare each result transfer with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    flag_mismatch("position, nothing pending", '0, i_position);
                end else begin
                    want = expected_results.pop_front();
                    if (i_position !== want.position)
                        flag_mismatch("position", want.position, i_position);
                    if (i_offset_value !== want.offset_value)
                        flag_mismatch("offset_value", want.offset_value, i_offset_value);
                end
                o_results++;
            end

            // predict each sample transfer
            if (i_in_valid && !i_in_stall)
                advance_tracker(i_high_byte, i_low_byte);
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== tb/tb_multiturn_angle_offset_tracker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multiturn_angle_offset_tracker_top - testbench for the angle tracker
// Drives directed and spinning-sensor samples with bursty input and a
// patterned result stall, moves the window registers between phases and
// lets the checker predict and compare every result.
// ----------------------------------------------------------------------------

module tb_multiturn_angle_offset_tracker_top;
    import maot_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 8;
    localparam int PHASE_ITEMS     = 230;
    localparam int NUM_PHASES      = 7;
    localparam int NUM_DIRECTED    = 16;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [7:0]         i_high_byte;
    logic [7:0]         i_low_byte;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [POS_W-1:0]   o_position;
    logic [POS_W-1:0]   o_offset_value;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int                 mismatches;
    int                 pending;
    int                 results;
    int                 cycle_count;
    int                 burst_left;
    int                 samples_sent;
    int                 settings_used;
    bit                 hold_off_req;
    logic [7:0]         spin_angle;
    bit                 spin_up;

    // {high_byte, low_byte}: offset retry, unused bits, turn thresholds
    logic [15:0] directed_samples [0:NUM_DIRECTED-1] = '{
        16'h0080, 16'hF080, 16'h0000, 16'h0FF0, 16'h000F, 16'h0C10,
        16'h03E0, 16'h0C00, 16'h03F0, 16'hFFFF, 16'h0000, 16'hAA55,
        16'h55AA, 16'h0007, 16'hF0F8, 16'h0FFF
    };

    multiturn_angle_offset_tracker_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_high_byte    (i_high_byte),
        .i_low_byte     (i_low_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_position     (o_position),
        .o_offset_value (o_offset_value),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    maot_tracker_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_high_byte    (i_high_byte),
        .i_low_byte     (i_low_byte),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_position     (o_position),
        .i_offset_value (o_offset_value),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_results      (results)
    );

    // Clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Abort a hung run
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("run timed out after %0d cycles, %0d results pending",
                     cycle_count, pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Stall results on shifting patterns, with a long hold-off on request
    initial begin : result_stall_pattern
        int mode;
        int span;
        int k;
        i_out_stall = 1'b0;
        forever begin
            mode = $urandom_range(0, 4);
            span = $urandom_range(8, 120);
            for (k = 0; k < span; k++) begin
                @(negedge i_clk);
                if (hold_off_req) begin
                    hold_off_req = 1'b0;
                    i_out_stall <= 1'b1;
                    repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                end else begin
                    case (mode)
                        0: i_out_stall <= 1'b0;
                        1: i_out_stall <= ($urandom_range(0, 3) == 0);
                        2: i_out_stall <= ($urandom_range(0, 3) != 0);
                        3: i_out_stall <= k[0];
                        default: i_out_stall <= $urandom_range(0, 1);
                    endcase
                end
            end
        end
    end

    // Register write: setup then access phase; called at a falling edge
    task automatic write_reg(input t_reg_idx idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Wait for the block to drain, then load both window registers
    task automatic configure_window(input logic [POS_W-1:0] centre,
                                    input logic [WIN_W-1:0] half);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        write_reg(t_REG_CENTER, PDATA_W'(centre));
        write_reg(t_REG_WINDOW, PDATA_W'(half));
        settings_used++;
    endtask

    // Offer one sample in bursts with idle gaps; called at a falling edge
    task automatic send_sample(input logic [7:0] hb, input logic [7:0] lb);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        i_in_valid  <= 1'b1;
        i_high_byte <= hb;
        i_low_byte  <= lb;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        burst_left--;
        samples_sent++;
    endtask

    // Spin the sensor steadily with random noise samples mixed in
    task automatic send_spinning(input int count, input int hold_at);
        int         n;
        logic [7:0] step;
        logic [7:0] hb;
        logic [7:0] lb;
        for (n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) < 2) begin
                hb = 8'($urandom);
                lb = 8'($urandom);
            end else begin
                step = 8'($urandom_range(30, 110));
                // jitter backwards now and then
                if (spin_up ^ ($urandom_range(0, 15) == 0))
                    spin_angle = spin_angle + step;
                else
                    spin_angle = spin_angle - step;
                hb = {4'($urandom), spin_angle[7:4]};
                lb = {spin_angle[3:0], 4'($urandom)};
            end
            if (n == hold_at)
                hold_off_req = 1'b1;
            send_sample(hb, lb);
        end
        i_in_valid <= 1'b0;
        burst_left = 0;
    endtask

    initial begin : stimulus
        int                 i;
        int                 phase;
        logic [POS_W-1:0]   centre;
        logic [WIN_W-1:0]   half;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_high_byte   = '0;
        i_low_byte    = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        hold_off_req  = 1'b0;
        burst_left    = 0;
        samples_sent  = 0;
        settings_used = 0;
        spin_angle    = '0;
        spin_up       = 1'b1;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: centre equal to the first raw value gives a zero initial
        // offset before the window pull, then walk the turn thresholds on both sides
        configure_window(16'h0010, 15'h5000);
        for (i = 0; i < NUM_DIRECTED; i++)
            send_sample(directed_samples[i][15:8], directed_samples[i][7:0]);
        i_in_valid <= 1'b0;
        burst_left = 0;

        // Random phases over default, extreme, wrapped and random windows
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin centre = CENTER_RESET; half = WINDOW_RESET; end
                1: begin centre = 16'h0000;     half = 15'h0000;     end
                2: begin centre = 16'hFFFF;     half = 15'h7FFF;     end
                3: begin centre = 16'($urandom); half = 15'($urandom); end
                4: begin centre = 16'h0100;     half = 15'h0040;     end
                5: begin centre = 16'h8000;     half = 15'h7FFF;     end
                default: begin
                    centre = 16'($urandom);
                    half   = 15'($urandom_range(0, 255));
                end
            endcase
            spin_up = (phase < 4);
            configure_window(centre, half);
            send_spinning(PHASE_ITEMS, (phase == 1) ? 60 : -1);
        end

        // Drain the pipeline before the verdict
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d sample transfers and %0d results over %0d window settings",
                 samples_sent, results, settings_used);
        $display("including a %0d-cycle result hold-off; %0d mismatches",
                 HOLD_OFF_CYCLES, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
